@@ hw/rtl/clc_pkg.sv @@
package clc_pkg;

  localparam int CFG_W     = 5;
  localparam int TAP_IDX_W = 4;
  localparam int OUT_W     = 37;

  localparam logic [CFG_W-1:0] TAP_COUNT_RST = CFG_W'(1);

  localparam logic MODE_TAP    = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Per-cell line control, driven by the top level each cycle
  typedef struct packed {
    logic push;    // shift the delay line by one sample
    logic clear;   // zero the delay line (end of block)
    logic tap_we;  // write this cell's tap
    logic active;  // cell index below the effective tap count
  } clc_cell_ctrl_t;

endpackage

@@ hw/rtl/clc_in_if.sv @@
interface clc_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [clc_pkg::TAP_IDX_W-1:0]     tap_index;
  logic signed [SAMPLE_BITS-1:0]     value_re;
  logic signed [SAMPLE_BITS-1:0]     value_im;
  logic                              block_end;

  modport source (
    output valid, mode, tap_index, value_re, value_im, block_end,
    input  ready
  );
  modport sink (
    input  valid, mode, tap_index, value_re, value_im, block_end,
    output ready
  );
endinterface

@@ hw/rtl/clc_out_if.sv @@
interface clc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [clc_pkg::OUT_W-1:0]   out_re;
  logic signed [clc_pkg::OUT_W-1:0]   out_im;
  logic                               out_last;

  modport source (
    output valid, out_re, out_im, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_re, out_im, out_last,
    output ready
  );
endinterface

@@ hw/rtl/clc_tap_cell.sv @@
module clc_tap_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  clc_pkg::clc_cell_ctrl_t        ctrl_i,
  input  logic                           en_prod_i,
  input  logic                           en_comb_i,
  input  logic signed [SAMPLE_BITS-1:0]  tap_re_i,
  input  logic signed [SAMPLE_BITS-1:0]  tap_im_i,
  input  logic signed [SAMPLE_BITS-1:0]  x_re_i,
  input  logic signed [SAMPLE_BITS-1:0]  x_im_i,
  output logic signed [SAMPLE_BITS-1:0]  x_re_o,
  output logic signed [SAMPLE_BITS-1:0]  x_im_o,
  output logic signed [2*SAMPLE_BITS:0]  c_re_o,
  output logic signed [2*SAMPLE_BITS:0]  c_im_o
);

  localparam int PW = 2 * SAMPLE_BITS;
  localparam int CW = PW + 1;

  logic signed [SAMPLE_BITS-1:0] tap_re_q, tap_im_q;
  logic signed [SAMPLE_BITS-1:0] x_re_q, x_im_q;
  logic signed [SAMPLE_BITS-1:0] t_re, t_im;
  logic signed [PW-1:0]          p_rr_d, p_ii_d, p_ri_d, p_ir_d;
  logic signed [PW-1:0]          p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [CW-1:0]          c_re_q, c_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_re_q <= '0;
      tap_im_q <= '0;
    end else if (ctrl_i.tap_we) begin
      tap_re_q <= tap_re_i;
      tap_im_q <= tap_im_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_re_q <= '0;
      x_im_q <= '0;
    end else if (ctrl_i.clear) begin
      x_re_q <= '0;
      x_im_q <= '0;
    end else if (ctrl_i.push) begin
      x_re_q <= x_re_i;
      x_im_q <= x_im_i;
    end
  end

  assign x_re_o = x_re_q;
  assign x_im_o = x_im_q;

  // taps beyond the count in use contribute nothing
  assign t_re = ctrl_i.active ? tap_re_q : '0;
  assign t_im = ctrl_i.active ? tap_im_q : '0;

  assign p_rr_d = PW'(t_re) * PW'(x_re_i);
  assign p_ii_d = PW'(t_im) * PW'(x_im_i);
  assign p_ri_d = PW'(t_re) * PW'(x_im_i);
  assign p_ir_d = PW'(t_im) * PW'(x_re_i);

  always_ff @(posedge clk_i) begin
    if (en_prod_i) begin
      p_rr_q <= p_rr_d;
      p_ii_q <= p_ii_d;
      p_ri_q <= p_ri_d;
      p_ir_q <= p_ir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_comb_i) begin
      c_re_q <= CW'(p_rr_q) - CW'(p_ii_q);
      c_im_q <= CW'(p_ri_q) + CW'(p_ir_q);
    end
  end

  assign c_re_o = c_re_q;
  assign c_im_o = c_im_q;

endmodule

@@ hw/rtl/clc_add_tree.sv @@
module clc_add_tree #(
  parameter int MAX_TAPS = 16,
  parameter int LEAF_W   = 33
) (
  input  logic                                         clk_i,
  input  logic [$clog2(MAX_TAPS)+1:0]                  en_i,
  input  logic signed [LEAF_W-1:0]                     leaf_re_i [MAX_TAPS],
  input  logic signed [LEAF_W-1:0]                     leaf_im_i [MAX_TAPS],
  output logic signed [LEAF_W+$clog2(MAX_TAPS)-1:0]    root_re_o,
  output logic signed [LEAF_W+$clog2(MAX_TAPS)-1:0]    root_im_o
);

  localparam int LEVELS = $clog2(MAX_TAPS);
  localparam int ACC_W  = LEAF_W + LEVELS;
  localparam int LEAVES = 1 << LEVELS;

  if (LEVELS == 0) begin : g_single
    assign root_re_o = leaf_re_i[0];
    assign root_im_o = leaf_im_i[0];
  end else begin : g_tree
    logic signed [ACC_W-1:0] leaf_re [LEAVES];
    logic signed [ACC_W-1:0] leaf_im [LEAVES];
    logic signed [ACC_W-1:0] node_re_q [LEAVES-1];
    logic signed [ACC_W-1:0] node_im_q [LEAVES-1];

    for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
      if (l < MAX_TAPS) begin : g_used
        assign leaf_re[l] = ACC_W'(leaf_re_i[l]);
        assign leaf_im[l] = ACC_W'(leaf_im_i[l]);
      end else begin : g_pad
        assign leaf_re[l] = '0;
        assign leaf_im[l] = '0;
      end
    end

    // heap order: node i has children 2i+1 and 2i+2, leaves follow the nodes
    for (genvar i = 0; i < LEAVES - 1; i++) begin : g_node
      localparam int DEPTH = $clog2(i + 2) - 1;
      localparam int STAGE = 1 + LEVELS - DEPTH;
      localparam int C_A   = 2 * i + 1;
      localparam int C_B   = 2 * i + 2;
      logic signed [ACC_W-1:0] a_re, a_im, b_re, b_im;

      if (C_A >= LEAVES - 1) begin : g_leaf_kids
        assign a_re = leaf_re[C_A-(LEAVES-1)];
        assign a_im = leaf_im[C_A-(LEAVES-1)];
        assign b_re = leaf_re[C_B-(LEAVES-1)];
        assign b_im = leaf_im[C_B-(LEAVES-1)];
      end else begin : g_node_kids
        assign a_re = node_re_q[C_A];
        assign a_im = node_im_q[C_A];
        assign b_re = node_re_q[C_B];
        assign b_im = node_im_q[C_B];
      end

      always_ff @(posedge clk_i) begin
        if (en_i[STAGE]) begin
          node_re_q[i] <= a_re + b_re;
          node_im_q[i] <= a_im + b_im;
        end
      end
    end

    assign root_re_o = node_re_q[0];
    assign root_im_o = node_im_q[0];
  end

endmodule

@@ hw/rtl/complex_linear_convolution.sv @@
// Complex FIR, full linear convolution of sample blocks with up to MAX_TAPS taps.
// Input channel in_i: mode selects a tap write (tap_index, value) or a sample
// push (value, block_end). Tap writes give no output and act on the next sample.
// Output channel out_o: one exact complex sum of products per sample, Q.30,
// truncated to 37 bits; out_last flags the final output of a block.
// Configuration: cfg_we_i/cfg_wdata_i write tap_count (0 acts as 1, values
// above MAX_TAPS act as MAX_TAPS); write only while the block is idle.
// Throughput: one transaction per cycle while the output is not stalled. A sample
// with block_end set is followed by tap_count-1 tail outputs; in_i.ready stays
// low while zeros are shifted through the delay line, which is then cleared.
// Pipeline: products registered at the accept edge, then complex combine and
// one registered adder-tree level per bit of clog2(MAX_TAPS).
// A stalled receiver holds the output transaction; pipeline bubbles still
// collapse, so input is accepted until every stage is full.
// Reset clears taps, delay line and pipeline valid flags, and sets tap_count to 1.
module complex_linear_convolution #(
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [clc_pkg::CFG_W-1:0]   cfg_wdata_i,
  clc_in_if.sink                      in_i,
  clc_out_if.source                   out_o
);

  localparam int TW     = $clog2(MAX_TAPS + 1);
  localparam int LEVELS = $clog2(MAX_TAPS);
  localparam int NST    = LEVELS + 2;
  localparam int CW     = 2 * SAMPLE_BITS + 1;
  localparam int ACC_W  = CW + LEVELS;
  localparam int EXT_W  = (ACC_W > clc_pkg::OUT_W) ? ACC_W : clc_pkg::OUT_W;

  logic [clc_pkg::CFG_W-1:0] cfg_q;
  logic [TW-1:0]             teff;
  logic                      flush_q;
  logic [TW-1:0]             fcnt_q;
  logic [NST-1:0]            v_q, last_q, en;

  logic accept, samp_acc, tap_acc, flush_iss, issue, t_last, iss_last;
  logic signed [SAMPLE_BITS-1:0] smp_re, smp_im;

  logic signed [SAMPLE_BITS-1:0] x_re [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] x_im [MAX_TAPS];
  logic signed [CW-1:0]          c_re [MAX_TAPS];
  logic signed [CW-1:0]          c_im [MAX_TAPS];
  clc_pkg::clc_cell_ctrl_t       ctrl [MAX_TAPS];

  logic signed [ACC_W-1:0] root_re, root_im;
  logic signed [EXT_W-1:0] ext_re, ext_im;

  always_comb begin
    if (cfg_q == '0) begin
      teff = TW'(1);
    end else if (32'(cfg_q) > 32'(MAX_TAPS)) begin
      teff = TW'(MAX_TAPS);
    end else begin
      teff = TW'(cfg_q);
    end
  end

  // stage k may load when empty or when the stage after it moves
  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0] && !flush_q;
  assign accept     = in_i.valid && in_i.ready;
  assign samp_acc   = accept && (in_i.mode == clc_pkg::MODE_SAMPLE);
  assign tap_acc    = accept && (in_i.mode == clc_pkg::MODE_TAP);
  assign flush_iss  = flush_q && en[0];
  assign issue      = samp_acc || flush_iss;
  assign t_last     = flush_q ? (fcnt_q == teff - TW'(1))
                              : (in_i.block_end && (teff == TW'(1)));
  assign iss_last   = issue && t_last;

  assign smp_re = flush_q ? '0 : in_i.value_re;
  assign smp_im = flush_q ? '0 : in_i.value_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= clc_pkg::TAP_COUNT_RST;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q <= 1'b0;
      fcnt_q  <= '0;
    end else if (samp_acc && in_i.block_end && (teff != TW'(1))) begin
      flush_q <= 1'b1;
      fcnt_q  <= TW'(1);
    end else if (flush_iss) begin
      if (t_last) begin
        flush_q <= 1'b0;
      end else begin
        fcnt_q <= fcnt_q + TW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      last_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0]    <= issue;
        last_q[0] <= iss_last;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k]    <= v_q[k-1];
          last_q[k] <= last_q[k-1];
        end
      end
    end
  end

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] xin_re, xin_im;

    assign ctrl[j].push   = issue;
    assign ctrl[j].clear  = iss_last;
    assign ctrl[j].tap_we = tap_acc && (32'(in_i.tap_index) == j);
    assign ctrl[j].active = (j < int'(teff));

    if (j == 0) begin : g_head
      assign xin_re = smp_re;
      assign xin_im = smp_im;
    end else begin : g_body
      assign xin_re = x_re[j-1];
      assign xin_im = x_im[j-1];
    end

    clc_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[j]),
      .en_prod_i (en[0]),
      .en_comb_i (en[1]),
      .tap_re_i  (in_i.value_re),
      .tap_im_i  (in_i.value_im),
      .x_re_i    (xin_re),
      .x_im_i    (xin_im),
      .x_re_o    (x_re[j]),
      .x_im_o    (x_im[j]),
      .c_re_o    (c_re[j]),
      .c_im_o    (c_im[j])
    );
  end

  clc_add_tree #(
    .MAX_TAPS (MAX_TAPS),
    .LEAF_W   (CW)
  ) u_tree (
    .clk_i     (clk_i),
    .en_i      (en),
    .leaf_re_i (c_re),
    .leaf_im_i (c_im),
    .root_re_o (root_re),
    .root_im_o (root_im)
  );

  assign ext_re = EXT_W'(root_re);
  assign ext_im = EXT_W'(root_im);

  assign out_o.valid    = v_q[NST-1];
  assign out_o.out_last = last_q[NST-1];
  assign out_o.out_re   = ext_re[clc_pkg::OUT_W-1:0];
  assign out_o.out_im   = ext_im[clc_pkg::OUT_W-1:0];

endmodule

@@ hw/rtl/clc_checker.sv @@
module clc_checker #(
  parameter int MAX_TAPS = 16
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [clc_pkg::CFG_W-1:0] cfg_wdata_i,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_mode_i,
  input logic                      in_block_end_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_last_i
);

  localparam int TW = $clog2(MAX_TAPS + 1);

  logic [clc_pkg::CFG_W-1:0] cfg_q;
  logic [TW-1:0]             teff;
  logic [7:0]                pend_q, pend_d;
  logic                      samp_acc, out_acc;

  always_comb begin
    if (cfg_q == '0) begin
      teff = TW'(1);
    end else if (32'(cfg_q) > 32'(MAX_TAPS)) begin
      teff = TW'(MAX_TAPS);
    end else begin
      teff = TW'(cfg_q);
    end
  end

  assign samp_acc = in_valid_i && in_ready_i && (in_mode_i == clc_pkg::MODE_SAMPLE);
  assign out_acc  = out_valid_i && out_ready_i;

  // results owed: one per sample, plus the tail at block end
  always_comb begin
    pend_d = pend_q;
    if (samp_acc) begin
      pend_d = pend_d + 8'(1);
      if (in_block_end_i) begin
        pend_d = pend_d + 8'(teff) - 8'(1);
      end
    end
    if (out_acc) begin
      pend_d = pend_d - 8'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= clc_pkg::TAP_COUNT_RST;
      pend_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      pend_q <= pend_d;
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_last_i))
    else $error("stalled output transaction dropped or changed");

  a_tail_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    samp_acc && in_block_end_i && (teff != TW'(1)) |=> !in_ready_i)
    else $error("input accepted during tail flush");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != '0))
    else $error("output transaction with no result owed");

endmodule

bind complex_linear_convolution clc_checker #(
  .MAX_TAPS (MAX_TAPS)
) u_clc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_we_i       (cfg_we_i),
  .cfg_wdata_i    (cfg_wdata_i),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_mode_i      (in_i.mode),
  .in_block_end_i (in_i.block_end),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_last_i     (out_o.out_last)
);
